// ----- rtl/median_sobel_3x3_window_filter_defines.svh -----
// assertion macros for the median / sobel window filter checker
// no dependencies
`ifndef MEDIAN_SOBEL_3X3_WINDOW_FILTER_DEFINES_SVH
`define MEDIAN_SOBEL_3X3_WINDOW_FILTER_DEFINES_SVH
// implication checked on every clock edge outside reset
`define MSF_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("msf check failed");
// next-cycle implication
`define MSF_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("msf check failed");
`endif

// ----- rtl/msf_pkg.sv -----
// shared types and constants for the median / sobel window filter
// no dependencies
`default_nettype none
package msf_pkg;
	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;
	localparam int unsigned CFG_W     = 11;
	localparam logic [11:0] SOBEL_BIAS = 12'd1024;

	typedef logic [7:0] pix_t;
	typedef pix_t [8:0] win_t;

	// one compare-exchange, smaller value in the upper byte
	function automatic logic [15:0] cswap(pix_t lo, pix_t hi);
		return (hi < lo) ? {hi, lo} : {lo, hi};
	endfunction

	// 19-exchange median network
	function automatic pix_t med9(win_t w);
		pix_t s [9];
		for (int i = 0; i < 9; i++) s[i] = w[i];
		{s[1], s[2]} = cswap(s[1], s[2]); {s[4], s[5]} = cswap(s[4], s[5]);
		{s[7], s[8]} = cswap(s[7], s[8]); {s[0], s[1]} = cswap(s[0], s[1]);
		{s[3], s[4]} = cswap(s[3], s[4]); {s[6], s[7]} = cswap(s[6], s[7]);
		{s[1], s[2]} = cswap(s[1], s[2]); {s[4], s[5]} = cswap(s[4], s[5]);
		{s[7], s[8]} = cswap(s[7], s[8]); {s[0], s[3]} = cswap(s[0], s[3]);
		{s[5], s[8]} = cswap(s[5], s[8]); {s[4], s[7]} = cswap(s[4], s[7]);
		{s[3], s[6]} = cswap(s[3], s[6]); {s[1], s[4]} = cswap(s[1], s[4]);
		{s[2], s[5]} = cswap(s[2], s[5]); {s[4], s[7]} = cswap(s[4], s[7]);
		{s[4], s[2]} = cswap(s[4], s[2]); {s[6], s[4]} = cswap(s[6], s[4]);
		{s[4], s[2]} = cswap(s[4], s[2]);
		return s[4];
	endfunction

	function automatic pix_t sobel(win_t w);
		logic signed [11:0] p, q;
		logic [10:0] ap, aq;
		logic [12:0] v;
		p = $signed({4'd0, w[2]}) + $signed({3'd0, w[5], 1'b0}) + $signed({4'd0, w[8]})
		  - $signed({4'd0, w[0]}) - $signed({3'd0, w[3], 1'b0}) - $signed({4'd0, w[6]});
		q = $signed({4'd0, w[6]}) + $signed({3'd0, w[7], 1'b0}) + $signed({4'd0, w[8]})
		  - $signed({4'd0, w[0]}) - $signed({3'd0, w[1], 1'b0}) - $signed({4'd0, w[2]});
		ap = p[11] ? 11'(-p) : 11'(p);
		aq = q[11] ? 11'(-q) : 11'(q);
		v = 13'(SOBEL_BIAS) + 13'(ap) + 13'(aq);
		return (v[12:3] > 10'd255) ? 8'd255 : v[10:3];
	endfunction
endpackage
`default_nettype wire

// ----- rtl/median_sobel_3x3_window_filter.sv -----
// 3x3 median / sobel window filter over a raster pixel stream, top level
// depends on msf_pkg and msf_ram
//
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: pixel_in[7:0]
// m_axis  | out | tdata: pixel_out[7:0] out_column[16:8] out_row[26:17]; tuser: frame_done;
//         |     | tlast: run_end
// cfg     | in  | we, idx, wdata (mode / width / height)
//
// one pixel can be accepted per cycle; inside a row below the top one a pixel emits
// one result on average (the top row emits none, and the extra result of the last
// column is absorbed by the queue), so rows stream at one pixel per cycle while the
// output is not stalled; bottom-row pixels emit two results (one at the first column,
// three at the last), so the bottom row runs slower, held back by the single output port
// stage 1 reads both line stores (registered ram read) and captures the pixel,
// stage 2 holds the window, the filter is computed from it into a result queue of
// eight, and results are presented from the queue head
// arst_n clears counters, window, mode and queue and sets the dimensions to 427 x 240;
// line stores are not cleared; s_axis_tready drops when the queue cannot take the
// results in flight plus those of the offered pixel
`default_nettype none
module median_sobel_3x3_window_filter #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // pixel_in
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [31:0] m_axis_tdata,   // pixel_out, out_column, out_row
	output logic             m_axis_tuser,   // frame_done
	output logic             m_axis_tlast,   // run_end
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_idx,
	input  wire logic [msf_pkg::CFG_W-1:0] cfg_wdata
);
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int HW = $clog2(MAX_HEIGHT);

	// result record
	typedef struct packed {
		logic [7:0]  pix;
		logic [8:0]  col;
		logic [9:0]  row;
		logic        done;
		logic        last;
	} res_t;

	logic        mode_q;
	logic [9:0]  fw_q;
	logic [10:0] fh_q;
	logic [AW-1:0] col_q;
	logic [HW-1:0] row_q;
	logic        sel_q;

	// effective dimensions
	logic [12:0] w_eff, h_eff;
	always_comb begin
		w_eff = (fw_q < 10'd3) ? 13'd3 :
			(13'(fw_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(fw_q);
		h_eff = (fh_q < 11'd3) ? 13'd3 :
			(13'(fh_q) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(fh_q);
	end

	logic acc;
	assign acc = s_axis_tvalid && s_axis_tready;

	logic col_last, row_last;
	assign col_last = (13'(col_q) == w_eff - 13'd1);
	assign row_last = (13'(row_q) == h_eff - 13'd1);

	// control and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			fw_q   <= 10'd427;
			fh_q   <= 11'd240;
			col_q  <= '0;
			row_q  <= '0;
			sel_q  <= 1'b0;
		end else if (cfg_we && (cfg_idx == msf_pkg::REG_WIDTH || cfg_idx == msf_pkg::REG_HEIGHT)) begin
			if (cfg_idx == msf_pkg::REG_WIDTH) fw_q <= cfg_wdata[9:0];
			else fh_q <= cfg_wdata;
			col_q <= '0;
			row_q <= '0;
			sel_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_idx == msf_pkg::REG_MODE) mode_q <= cfg_wdata[0];
			if (acc) begin
				if (col_last) begin
					col_q <= '0;
					sel_q <= ~sel_q;
					row_q <= row_last ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	// line stores: older is written with the new pixel, both read at the column
	logic [7:0] up_rd, lo_rd;
	msf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_up (
		.clk(clk), .we(acc && !sel_q), .waddr(col_q), .wdata(s_axis_tdata),
		.re(acc), .raddr(col_q), .rdata(up_rd));
	msf_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_lo (
		.clk(clk), .we(acc && sel_q), .waddr(col_q), .wdata(s_axis_tdata),
		.re(acc), .raddr(col_q), .rdata(lo_rd));

	// stage 1: pixel and position alongside the ram read
	logic        v_s1, sel_s1, cl_s1, rl_s1;
	logic [7:0]  px_s1;
	logic [AW-1:0] col_s1;
	logic [HW-1:0] row_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= acc;
	end
	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1 <= s_axis_tdata; sel_s1 <= sel_q; col_s1 <= col_q; row_s1 <= row_q;
			cl_s1 <= col_last; rl_s1 <= row_last;
		end
	end

	// stage 2: window shift
	msf_pkg::win_t win_q, win_n;
	always_comb begin
		win_n = win_q;
		win_n[0] = win_q[1]; win_n[1] = win_q[2]; win_n[2] = sel_s1 ? lo_rd : up_rd;
		win_n[3] = win_q[4]; win_n[4] = win_q[5]; win_n[5] = sel_s1 ? up_rd : lo_rd;
		win_n[6] = win_q[7]; win_n[7] = win_q[8]; win_n[8] = px_s1;
	end
	logic        v_s2, cl_s2, rl_s2;
	logic [7:0]  px_s2;
	logic [AW-1:0] col_s2;
	logic [HW-1:0] row_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			win_q <= '0;
		end else begin
			v_s2 <= v_s1;
			if (v_s1) win_q <= win_n;
		end
	end
	always_ff @(posedge clk) begin
		if (v_s1) begin
			px_s2 <= px_s1; col_s2 <= col_s1; row_s2 <= row_s1;
			cl_s2 <= cl_s1; rl_s2 <= rl_s1;
		end
	end

	// filter and result generation
	res_t r0, r1, r2;
	logic e0, e1, e2;
	logic inner, edge_r;
	logic [7:0] fv;
	always_comb begin
		edge_r = (row_s2 != '0) && (col_s2 != '0);
		inner  = (row_s2 > HW'(1)) && (col_s2 > AW'(1));
		if (inner) fv = mode_q ? msf_pkg::sobel(win_q) : msf_pkg::med9(win_q);
		else fv = mode_q ? 8'd0 : win_q[4];
		e0 = edge_r;
		e1 = edge_r && cl_s2;
		e2 = rl_s2;
		r0 = '{pix: fv, col: 9'(col_s2 - 1'b1), row: 10'(row_s2 - 1'b1), done: 1'b0,
			last: !(e1 || e2)};
		r1 = '{pix: mode_q ? 8'd0 : win_q[5], col: 9'(col_s2), row: 10'(row_s2 - 1'b1),
			done: 1'b0, last: !e2};
		r2 = '{pix: mode_q ? 8'd0 : px_s2, col: 9'(col_s2), row: 10'(row_s2),
			done: cl_s2, last: 1'b1};
	end

	// result queue of eight, up to three written per cycle
	res_t q_q [8];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;
	logic [1:0] nw;
	logic pop;
	assign nw  = v_s2 ? (2'(e0) + 2'(e1) + 2'(e2)) : 2'd0;
	assign pop = m_axis_tvalid && m_axis_tready;
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (e0) q_q[wp_q] <= r0;
			if (e1) q_q[wp_q + 3'd1] <= r1;
			if (e2) q_q[wp_q + 3'(e0) + 3'(e1)] <= r2;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + 3'(nw);
			rp_q  <= rp_q + 3'(pop);
			cnt_q <= cnt_q + 4'(nw) - 4'(pop);
		end
	end
	// results owed by the offered pixel and by the one in stage 1
	logic ed_in, ed_s1;
	logic [1:0] n_in, n_s1;
	assign ed_in = (row_q != '0) && (col_q != '0);
	assign n_in  = 2'(ed_in) + 2'(ed_in && col_last) + 2'(row_last);
	assign ed_s1 = (row_s1 != '0) && (col_s1 != '0);
	assign n_s1  = v_s1 ? (2'(ed_s1) + 2'(ed_s1 && cl_s1) + 2'(rl_s1)) : 2'd0;
	assign s_axis_tready = (5'(cnt_q) + 5'(nw) + 5'(n_s1) + 5'(n_in)) <= 5'd8;
	assign m_axis_tvalid = (cnt_q != '0);
	res_t hd;
	assign hd = q_q[rp_q];
	assign m_axis_tdata = {5'd0, hd.row, hd.col, hd.pix};
	assign m_axis_tuser = hd.done;
	assign m_axis_tlast = hd.last;
endmodule
`default_nettype wire

// ----- rtl/msf_ram.sv -----
// generic single-port-write, registered-read ram
// no dependencies
`default_nettype none
module msf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/msf_checker.sv -----
// port-level checker for the median / sobel window filter, with its bind
// depends on median_sobel_3x3_window_filter_defines.svh
`default_nettype none
`include "median_sobel_3x3_window_filter_defines.svh"
module msf_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata,
	input wire logic        m_axis_tuser,
	input wire logic        m_axis_tlast
);
	`MSF_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	`MSF_ASSERT_IMP(a_done_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)
	`MSF_ASSERT_IMP(a_pad, m_axis_tvalid, m_axis_tdata[31:27] == 5'd0)
endmodule
bind median_sobel_3x3_window_filter msf_checker u_msf_checker (.*);
`default_nettype wire

// ----- sim/tb_top.sv -----
// self-checking testbench for the median / sobel window filter
// depends on msf_pkg and median_sobel_3x3_window_filter; holds its own pixel predictor
`default_nettype none
module tb_top;
	typedef struct packed {
		logic [7:0] value;
		logic [8:0] col;
		logic [9:0] row;
		logic       done;
		logic       last;
	} filt_res_t;

	typedef logic [msf_pkg::CFG_W-1:0] cfg_val_t;

	// predictor of the filter plus the queue of results it expects
	class filter_scoreboard;
		logic [7:0] bank_a [512];
		logic [7:0] bank_b [512];
		logic [7:0] win [9];
		int unsigned col_cnt, row_cnt;
		bit bank_sel;
		bit sobel_on;
		int unsigned width_reg, height_reg;
		filt_res_t pending_q [$];
		int errors;

		function void init();
			foreach (win[i]) win[i] = '0;
			col_cnt = 0;
			row_cnt = 0;
			bank_sel = 0;
			sobel_on = 0;
			width_reg = 427;
			height_reg = 240;
			errors = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [msf_pkg::CFG_W-1:0] val);
			if (idx == msf_pkg::REG_MODE) begin
				sobel_on = val[0];
			end else if (idx == msf_pkg::REG_WIDTH || idx == msf_pkg::REG_HEIGHT) begin
				if (idx == msf_pkg::REG_WIDTH) width_reg = 32'(val[9:0]);
				else height_reg = 32'(val[10:0]);
				col_cnt = 0;
				row_cnt = 0;
				bank_sel = 0;
			end
		endfunction

		// median by plain insertion sort
		function logic [7:0] middle_of_nine();
			logic [7:0] s [9];
			logic [7:0] t;
			int j;
			foreach (s[i]) s[i] = win[i];
			for (int i = 1; i < 9; i++) begin
				t = s[i];
				j = i - 1;
				while (j >= 0 && s[j] > t) begin
					s[j + 1] = s[j];
					j--;
				end
				s[j + 1] = t;
			end
			return s[4];
		endfunction

		function logic [7:0] edge_strength();
			int gx, gy, v;
			gx = win[2] + 2 * win[5] + win[8] - win[0] - 2 * win[3] - win[6];
			gy = win[6] + 2 * win[7] + win[8] - win[0] - 2 * win[1] - win[2];
			if (gx < 0) gx = -gx;
			if (gy < 0) gy = -gy;
			v = (1024 + gx + gy) / 8;
			return (v > 255) ? 8'd255 : v[7:0];
		endfunction

		function void push(logic [7:0] v, int unsigned c, int unsigned r, bit d);
			filt_res_t e;
			e.value = v;
			e.col = c[8:0];
			e.row = r[9:0];
			e.done = d;
			e.last = 0;
			pending_q.push_back(e);
		endfunction

		// accepted pixel request: advance the window and queue its results
		function void note_pixel(logic [7:0] px);
			int unsigned w, h, c, r, n0;
			logic [7:0] top, mid, v;
			w = (width_reg < 3) ? 3 : (width_reg > 512) ? 512 : width_reg;
			h = (height_reg < 3) ? 3 : (height_reg > 1024) ? 1024 : height_reg;
			c = (col_cnt >= w) ? 0 : col_cnt;
			r = (row_cnt >= h) ? 0 : row_cnt;
			n0 = pending_q.size();
			if (bank_sel) begin
				top = bank_b[c];
				mid = bank_a[c];
				bank_b[c] = px;
			end else begin
				top = bank_a[c];
				mid = bank_b[c];
				bank_a[c] = px;
			end
			for (int i = 0; i < 9; i += 3) begin
				win[i] = win[i + 1];
				win[i + 1] = win[i + 2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = px;
			if (r >= 1 && c >= 1) begin
				if (r >= 2 && c >= 2) v = sobel_on ? edge_strength() : middle_of_nine();
				else v = sobel_on ? 8'd0 : win[4];
				push(v, c - 1, r - 1, 0);
				if (c == w - 1) push(sobel_on ? 8'd0 : win[5], c, r - 1, 0);
			end
			if (r == h - 1) push(sobel_on ? 8'd0 : px, c, r, c == w - 1);
			if (pending_q.size() > n0) pending_q[$].last = 1;
			c++;
			if (c >= w) begin
				c = 0;
				bank_sel = ~bank_sel;
				r++;
				if (r >= h) r = 0;
			end
			col_cnt = c;
			row_cnt = r;
		endfunction

		function void check(filt_res_t got);
			filt_res_t e;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %p", got);
				return;
			end
			e = pending_q.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10) $display("mismatch: expected %p got %p", e, got);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata;   // pixel_in
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [31:0] m_axis_tdata;  // pixel_out, out_column, out_row
	logic m_axis_tuser;         // frame_done
	logic m_axis_tlast;         // run_end
	logic cfg_we;
	logic [1:0] cfg_idx;
	logic [msf_pkg::CFG_W-1:0] cfg_wdata;

	filter_scoreboard sb;
	bit steady;           // when set neither side idles
	int random_pixels;

	median_sobel_3x3_window_filter uut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// result side: check every accepted result, stall about 30 percent of cycles unless steady
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check({m_axis_tdata[7:0], m_axis_tdata[16:8], m_axis_tdata[26:17],
				m_axis_tuser, m_axis_tlast});
		m_axis_tready <= steady || ($urandom_range(99) >= 30);
	end

	// register write while the block is idle
	task automatic write_reg(logic [1:0] idx, cfg_val_t val);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
		@(posedge clk);
	endtask

	// one pixel request, at times with a random gap before it, never when steady
	task automatic send_pixel(logic [7:0] px);
		if (!steady && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 2)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= px;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_pixel(px);
	endtask

	// let the result queue drain, then the pipeline settle
	task automatic drain();
		s_axis_tvalid <= 0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	function automatic logic [7:0] pick_pixel();
		int k;
		k = $urandom_range(99);
		if (k < 15) return 8'd0;
		if (k < 30) return 8'd255;
		return 8'($urandom_range(255));
	endfunction

	// full frame with the given geometry; kind 0 random, 1 checkerboard extremes
	task automatic run_frame(bit mode, int unsigned wv, int unsigned hv, int unsigned npix,
			int kind);
		write_reg(msf_pkg::REG_MODE, cfg_val_t'(mode));
		write_reg(msf_pkg::REG_WIDTH, cfg_val_t'(wv));
		write_reg(msf_pkg::REG_HEIGHT, cfg_val_t'(hv));
		for (int i = 0; i < npix; i++)
			send_pixel(kind == 1 ? (((i % 3) + (i / 3)) % 2 ? 8'd255 : 8'd0) : pick_pixel());
		drain();
	endtask

	initial begin
		int unsigned wv, hv, np;
		sb = new();
		sb.init();
		steady = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		m_axis_tready = 0;
		cfg_we = 0;
		cfg_idx = msf_pkg::REG_MODE;
		cfg_wdata = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: smallest frames with extreme pixels in both modes
		run_frame(0, 3, 3, 9, 1);
		run_frame(1, 3, 3, 9, 1);
		// dimensions below range clamp to three
		run_frame(1, 0, 1, 9, 0);
		// unknown register index is ignored
		write_reg(2'd3, '1);
		// long stretch with no idling on either side
		steady = 1;
		run_frame(0, 8, 4, 32, 0);
		steady = 0;

		// random frames of small size, two frames back to back at times
		random_pixels = 0;
		while (random_pixels < 50) begin
			wv = $urandom_range(3, 10);
			hv = $urandom_range(3, 6);
			np = wv * hv * $urandom_range(1, 2);
			steady = ($urandom_range(3) == 0);
			run_frame(1'($urandom_range(1)), wv, hv, np, 0);
			random_pixels += np;
		end
		steady = 0;
		drain();

		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#8000000;
		$display("FAILURE");
		$finish;
	end
endmodule
`default_nettype wire
